// File: rtl/assert_macros.svh
// Assertion macros shared by the RDS text and name assembler RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/rtna_pkg.sv
// Package for the RDS text and name assembler: beat payload types,
// command, variant and register codes. No dependencies.
`default_nettype none

package rtna_pkg;

  // Command codes
  localparam logic [2:0] CMD_GROUP       = 3'd0;
  localparam logic [2:0] CMD_READ_NAME   = 3'd1;
  localparam logic [2:0] CMD_READ_TEXT_A = 3'd2;
  localparam logic [2:0] CMD_READ_TEXT_B = 3'd3;
  localparam logic [2:0] CMD_CLEAR       = 3'd4;

  // Radiotext variant codes
  localparam logic [1:0] VARIANT_A    = 2'd0;
  localparam logic [1:0] VARIANT_B    = 2'd1;
  localparam logic [1:0] VARIANT_NONE = 2'd2;

  // Group codes (type and version bits) carrying radiotext
  localparam logic [4:0] GROUP_2A = 5'd4;
  localparam logic [4:0] GROUP_2B = 5'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_NAME_LIMIT = 2'd0;
  localparam logic [1:0] REG_TEXT_A_GOAL = 2'd1;
  localparam logic [1:0] REG_TEXT_B_GOAL = 2'd2;

  // Register reset values
  localparam logic [15:0] NAME_LIMIT_RESET  = 16'd500;
  localparam logic [4:0]  TEXT_A_GOAL_RESET = 5'd10;
  localparam logic [4:0]  TEXT_B_GOAL_RESET = 5'd8;

  // Store geometry
  localparam int NAME_SEGS    = 4;
  localparam int TEXT_SEGS    = 16;
  localparam int TEXT_A_LEN   = 64;
  localparam int TEXT_B_LEN   = 32;
  localparam logic [2:0] NAME_SEG_DONE = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] block_b;
    logic [15:0] block_c;
    logic [15:0] block_d;
    logic        sync_ok;
    logic [5:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [4:0] group_code;
    logic [4:0] programme_type;
    logic       group_valid;
    logic [7:0] char_out;
    logic       name_ready;
    logic       text_ready;
    logic [1:0] text_variant;
  } result_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_write_t;

endpackage

`default_nettype wire

// File: rtl/rtna_if.sv
// Valid/ready channel interfaces of the RDS text and name assembler.
// Depends on rtna_pkg for the beat payload types.
`default_nettype none

interface rtna_item_if;
  logic                 valid;
  logic                 ready;
  rtna_pkg::item_t      data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rtna_result_if;
  logic                 valid;
  logic                 ready;
  rtna_pkg::result_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rtna_cfg_if;
  logic                 valid;
  logic                 ready;
  rtna_pkg::cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/rds_text_and_name_assembler_unit.sv
// RDS programme-service name and radiotext assembler, top level.
// Depends on rtna_pkg, the channel interfaces in rtna_if and assert_macros.svh.
//
// Each item beat carries one command: a group (blocks B, C, D and sync flag),
// a character read, or a clear. Every item produces exactly one result beat,
// registered, in the cycle after the item is taken. One item is accepted per
// cycle; the only thing that holds input back is a result still waiting at
// the output register. The name store (4 segments of 2 chars), text A store
// (16 rows of 4 chars) and text B store (16 rows of 2 chars) are flip-flop
// rows; text rows carry valid bits so a clear command empties them at once.
// Configuration writes are always accepted, one per cycle; index 3 is ignored.
`default_nettype none
`include "assert_macros.svh"

module rds_text_and_name_assembler_unit (
  input  wire logic     clk,
  input  wire logic     rst,
  rtna_item_if.sink     item,
  rtna_result_if.source result,
  rtna_cfg_if.sink      cfg
);
  import rtna_pkg::*;

  // Configuration registers
  logic [15:0] name_limit;
  logic [4:0]  a_goal;
  logic [4:0]  b_goal;

  // Assembly state
  logic [3:0]  name_marks, name_marks_next;
  logic [2:0]  name_count, name_count_next;
  logic        name_done, name_done_next;
  logic [15:0] name_rows [NAME_SEGS];
  logic [15:0] a_marks, a_marks_next;
  logic [4:0]  a_count, a_count_next;
  logic [31:0] a_rows [TEXT_SEGS];
  logic [15:0] a_row_valid, a_row_valid_next;
  logic [15:0] b_marks, b_marks_next;
  logic [4:0]  b_count, b_count_next;
  logic [15:0] b_rows [TEXT_SEGS];
  logic [15:0] b_row_valid, b_row_valid_next;
  logic        text_done, text_done_next;
  logic [1:0]  last_variant, last_variant_next;

  // Output register
  logic        res_valid;
  result_t     res_data, res_data_next;

  // Decode and write strobes
  logic        go;
  item_t       it;
  logic [1:0]  name_seg;
  logic [3:0]  text_seg;
  logic [4:0]  code;
  logic        name_wr, a_wr, b_wr;
  logic [31:0] a_row_rd, a_shift;
  logic [15:0] b_row_rd, name_row_rd;

  assign it   = item.data;
  assign go   = item.valid && item.ready;
  assign item.ready   = !res_valid || result.ready;
  assign result.valid = res_valid;
  assign result.data  = res_data;
  assign cfg.ready    = 1'b1;

  assign name_seg = it.block_b[1:0];
  assign text_seg = it.block_b[3:0];
  assign code     = it.block_b[15:11];

  // Read-side row selection
  assign name_row_rd = name_rows[it.read_index[2:1]];
  assign a_row_rd    = a_row_valid[it.read_index[5:2]] ? a_rows[it.read_index[5:2]] : '0;
  assign a_shift     = a_row_rd >> {~it.read_index[1:0], 3'b000};
  assign b_row_rd    = b_row_valid[it.read_index[4:1]] ? b_rows[it.read_index[4:1]] : '0;

  // Per-item update of state and result
  always_comb begin
    name_marks_next   = name_marks;
    name_count_next   = name_count;
    name_done_next    = name_done;
    a_marks_next      = a_marks;
    a_count_next      = a_count;
    a_row_valid_next  = a_row_valid;
    b_marks_next      = b_marks;
    b_count_next      = b_count;
    b_row_valid_next  = b_row_valid;
    text_done_next    = text_done;
    last_variant_next = last_variant;
    name_wr = 1'b0;
    a_wr    = 1'b0;
    b_wr    = 1'b0;
    res_data_next = '0;

    unique case (it.command)
      CMD_GROUP: begin
        // name segment, taken regardless of sync
        if (!name_marks[name_seg] && (it.block_b < name_limit)) begin
          name_wr         = 1'b1;
          name_marks_next = name_marks | (4'b0001 << name_seg);
          name_count_next = name_count + 3'd1;
        end
        if (name_count_next == NAME_SEG_DONE) begin
          name_done_next  = 1'b1;
          name_count_next = '0;
          name_marks_next = '0;
        end
        // radiotext, only with sync
        if (it.sync_ok) begin
          res_data_next.group_code     = code;
          res_data_next.programme_type = it.block_b[9:5];
          res_data_next.group_valid    = 1'b1;
          if (code == GROUP_2A) begin
            last_variant_next = VARIANT_A;
            if (!a_marks[text_seg]) begin
              a_wr = 1'b1;
              a_row_valid_next[text_seg] = 1'b1;
              a_marks_next[text_seg]     = 1'b1;
              a_count_next               = a_count + 5'd1;
            end
            if (a_count_next >= a_goal) begin
              text_done_next = 1'b1;
              a_marks_next   = '0;
              a_count_next   = '0;
            end
          end else if (code == GROUP_2B) begin
            last_variant_next = VARIANT_B;
            if (!b_marks[text_seg]) begin
              b_wr = 1'b1;
              b_row_valid_next[text_seg] = 1'b1;
              b_marks_next[text_seg]     = 1'b1;
              b_count_next               = b_count + 5'd1;
            end
            if (b_count_next >= b_goal) begin
              text_done_next = 1'b1;
              b_marks_next   = '0;
              b_count_next   = '0;
            end
          end
        end
      end
      CMD_READ_NAME: begin
        if (it.read_index[5:3] == 3'd0) begin
          res_data_next.char_out = it.read_index[0] ? name_row_rd[7:0] : name_row_rd[15:8];
        end
      end
      CMD_READ_TEXT_A: begin
        res_data_next.char_out = a_shift[7:0];
      end
      CMD_READ_TEXT_B: begin
        if (!it.read_index[5]) begin
          res_data_next.char_out = it.read_index[0] ? b_row_rd[7:0] : b_row_rd[15:8];
        end
      end
      CMD_CLEAR: begin
        name_marks_next   = '0;
        name_count_next   = '0;
        name_done_next    = 1'b0;
        a_marks_next      = '0;
        a_count_next      = '0;
        a_row_valid_next  = '0;
        b_marks_next      = '0;
        b_count_next      = '0;
        b_row_valid_next  = '0;
        text_done_next    = 1'b0;
        last_variant_next = VARIANT_NONE;
      end
      default: begin
        // unused command codes: no state change
      end
    endcase

    res_data_next.name_ready   = name_done_next;
    res_data_next.text_ready   = text_done_next;
    res_data_next.text_variant = last_variant_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      name_limit <= NAME_LIMIT_RESET;
      a_goal     <= TEXT_A_GOAL_RESET;
      b_goal     <= TEXT_B_GOAL_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_NAME_LIMIT:  name_limit <= cfg.data.data;
        REG_TEXT_A_GOAL: a_goal     <= cfg.data.data[4:0];
        REG_TEXT_B_GOAL: b_goal     <= cfg.data.data[4:0];
        default: ;
      endcase
    end
  end

  // Control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      name_marks   <= '0;
      name_count   <= '0;
      name_done    <= 1'b0;
      a_marks      <= '0;
      a_count      <= '0;
      a_row_valid  <= '0;
      b_marks      <= '0;
      b_count      <= '0;
      b_row_valid  <= '0;
      text_done    <= 1'b0;
      last_variant <= VARIANT_NONE;
      res_valid    <= 1'b0;
    end else begin
      if (go) begin
        name_marks   <= name_marks_next;
        name_count   <= name_count_next;
        name_done    <= name_done_next;
        a_marks      <= a_marks_next;
        a_count      <= a_count_next;
        a_row_valid  <= a_row_valid_next;
        b_marks      <= b_marks_next;
        b_count      <= b_count_next;
        b_row_valid  <= b_row_valid_next;
        text_done    <= text_done_next;
        last_variant <= last_variant_next;
        res_valid    <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (go) begin
      res_data <= res_data_next;
    end
  end

  // Name store: resets to zero, kept across clear
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NAME_SEGS; i++) begin
        name_rows[i] <= '0;
      end
    end else if (go && name_wr) begin
      name_rows[name_seg] <= it.block_d;
    end
  end

  // Text stores: rows qualified by valid bits
  always_ff @(posedge clk) begin
    if (go && a_wr) begin
      a_rows[text_seg] <= {it.block_c, it.block_d};
    end
    if (go && b_wr) begin
      b_rows[text_seg] <= it.block_d;
    end
  end

  // Checks
  `ASSERT_IMPLIES(a_name_count_range, clk, rst, 1'b1, name_count < NAME_SEG_DONE)
  `ASSERT_IMPLIES(a_name_count_marks, clk, rst, 1'b1, $countones(name_marks) == name_count)
  `ASSERT_NEXT(a_sync_group_valid, clk, rst, go && it.command == CMD_GROUP && it.sync_ok, res_valid && res_data.group_valid)
  `ASSERT_NEXT(a_clear_flags, clk, rst, go && it.command == CMD_CLEAR, !name_done && !text_done && last_variant == VARIANT_NONE)

endmodule

`default_nettype wire
